// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each one samples on clk and is
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define CTBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define CTBC_NEVER(label, expr, msg) \
	`CTBC_ASSERT(label, !(expr), msg)

`endif

// ===== sv/ctbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctbc_pkg
// Types, constants and helper functions shared by the red-blob centroid
// tracker modules.
// ----------------------------------------------------------------------------
package ctbc_pkg;

	// Largest frame the counters and accumulators are sized for.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Fixed field widths.
	localparam int COLOR_W  = 8;
	localparam int CFG_W    = 11;
	localparam int MARGIN_W = 8;
	localparam int CENT_W   = 14;
	localparam int FRAC_W   = 4;
	localparam int CENT_MAX = (1 << CENT_W) - 1;

	// Derived widths of counters, sums and the quotient.
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CRD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CNT_W  = COL_W + ROW_W + 1;
	localparam int SUM_W  = CRD_W + CNT_W;
	localparam int Q_W    = CRD_W + FRAC_W;
	localparam int QCNT_W = $clog2(Q_W + 1);
	localparam int DIM_W  = (CFG_W > CRD_W + 1) ? CFG_W : CRD_W + 1;
	localparam int SAT_W  = (Q_W > CENT_W) ? Q_W : CENT_W;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MARGIN = 2'd2;

	// Register values after reset.
	localparam logic [CFG_W-1:0]    WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0]    HEIGHT_RST = 11'd400;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd100;

	// Decoupling queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// One classified pixel as handed from the front end to the back end.
	typedef struct packed {
		logic             mask;
		logic             frame_done;
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [CNT_W-1:0] count;
	} ctbc_rec_t;

	// Last valid index of a frame dimension; zero acts as one, and sizes
	// above the maximum act as the maximum.
	function automatic logic [CRD_W-1:0] last_index(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		logic [DIM_W-1:0] ve;
		logic [DIM_W-1:0] lim;
		logic [DIM_W-1:0] res;
		ve  = DIM_W'(v);
		lim = DIM_W'(maxv);
		if (ve == '0) begin
			res = '0;
		end else if (ve > lim) begin
			res = lim - DIM_W'(1);
		end else begin
			res = ve - DIM_W'(1);
		end
		return res[CRD_W-1:0];
	endfunction

	// Clip a quotient to the centroid field range.
	function automatic logic [CENT_W-1:0] sat_cent(input logic [Q_W-1:0] q);
		logic [SAT_W-1:0] qe;
		qe = SAT_W'(q);
		if (qe > SAT_W'(CENT_MAX)) begin
			qe = SAT_W'(CENT_MAX);
		end
		return qe[CENT_W-1:0];
	endfunction

endpackage

// ===== sv/ctbc_front.sv =====
// ----------------------------------------------------------------------------
// ctbc_front
// Accepts pixels, holds the configuration, classifies each pixel against
// the color margin, walks the raster counters and accumulates the marked
// coordinates. Every accepted pixel becomes one queue record.
// ----------------------------------------------------------------------------
module ctbc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ctbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctbc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ctbc_pkg::COLOR_W-1:0]     red,
	input  logic [ctbc_pkg::COLOR_W-1:0]     green,
	input  logic [ctbc_pkg::COLOR_W-1:0]     blue,
	input  logic                             queue_full,
	output logic                             push,
	output ctbc_pkg::ctbc_rec_t              push_rec
);
	import ctbc_pkg::*;

	logic [CFG_W-1:0]    frame_width_q;
	logic [CFG_W-1:0]    frame_height_q;
	logic [MARGIN_W-1:0] color_margin_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;
	logic [CNT_W-1:0] count_q;

	logic [CRD_W-1:0]   col_last;
	logic [CRD_W-1:0]   row_last;
	logic               accept;
	logic               marked;
	logic               row_end;
	logic               frame_end;
	logic [SUM_W-1:0]   sum_x_next;
	logic [SUM_W-1:0]   sum_y_next;
	logic [CNT_W-1:0]   count_next;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			color_margin_q <= MARGIN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_COLOR_MARGIN: color_margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end only stalls when the queue has no room.
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// Red must beat both other channels by more than the margin.
	assign marked = ({1'b0, red} > ({1'b0, blue} + {1'b0, color_margin_q})) &&
		({1'b0, red} > ({1'b0, green} + {1'b0, color_margin_q}));

	// Row and frame end, robust to a frame size that shrank mid-frame.
	assign col_last  = last_index(frame_width_q, MAX_WIDTH);
	assign row_last  = last_index(frame_height_q, MAX_HEIGHT);
	assign row_end   = CRD_W'(col_q) >= col_last;
	assign frame_end = row_end && (CRD_W'(row_q) >= row_last);

	// Accumulators including the current pixel.
	assign sum_x_next = sum_x_q + (marked ? SUM_W'(col_q) : '0);
	assign sum_y_next = sum_y_q + (marked ? SUM_W'(row_q) : '0);
	assign count_next = count_q + CNT_W'(marked);

	always_comb begin
		push_rec.mask       = marked;
		push_rec.frame_done = frame_end;
		push_rec.sum_x      = sum_x_next;
		push_rec.sum_y      = sum_y_next;
		push_rec.count      = count_next;
	end

	// Raster counters and accumulators, cleared at the end of each frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				count_q <= '0;
			end else begin
				sum_x_q <= sum_x_next;
				sum_y_q <= sum_y_next;
				count_q <= count_next;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/ctbc_queue.sv =====
// ----------------------------------------------------------------------------
// ctbc_queue
// Short register queue that decouples the pixel front end from the
// centroid back end.
// ----------------------------------------------------------------------------
module ctbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ctbc_pkg::ctbc_rec_t push_rec,
	output logic                full,
	input  logic                pop,
	output ctbc_pkg::ctbc_rec_t pop_rec,
	output logic                empty
);
	import ctbc_pkg::*;

	`include "assert_macros.svh"

	ctbc_rec_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign full    = fill_q == QFILL_W'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign pop_rec = entry_q[rd_ptr_q];

	// Storage; the entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

	`CTBC_NEVER(a_fill_bound, fill_q > QFILL_W'(QUEUE_DEPTH), "queue fill above depth")
	`CTBC_ASSERT(a_pop_drains, pop && !push |=> fill_q == $past(fill_q) - QFILL_W'(1), "pop did not drain")

endmodule

// ===== sv/ctbc_div.sv =====
// ----------------------------------------------------------------------------
// ctbc_div
// Bit-serial restoring divider that forms the mean coordinate with four
// fraction bits, one quotient bit per step.
// ----------------------------------------------------------------------------
module ctbc_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [ctbc_pkg::SUM_W-1:0]  sum,
	input  logic [ctbc_pkg::CNT_W-1:0]  divisor,
	output logic [ctbc_pkg::Q_W-1:0]    quot
);
	import ctbc_pkg::*;

	logic [CNT_W-1:0] rem_q;
	logic [Q_W-1:0]   shr_q;
	logic [CNT_W-1:0] div_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, shr_q[Q_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};
	assign quot  = shr_q;

	// The high part of the dividend is already below the divisor, so only
	// the low coordinate bits and the fraction bits produce quotient bits.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= sum[SUM_W-1:CRD_W];
			shr_q <= {sum[CRD_W-1:0], FRAC_W'(0)};
			div_q <= divisor;
		end else if (step) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			shr_q <= {shr_q[Q_W-2:0], fits};
		end
	end

endmodule

// ===== sv/ctbc_back.sv =====
// ----------------------------------------------------------------------------
// ctbc_back
// Drains queue records into the output register. Ordinary pixels pass
// straight through; a frame end with marked pixels first runs the two
// centroid divisions.
// ----------------------------------------------------------------------------
module ctbc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  ctbc_pkg::ctbc_rec_t          pop_rec,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         mask,
	output logic                         frame_done,
	output logic                         found,
	output logic [ctbc_pkg::CENT_W-1:0]  centroid_x,
	output logic [ctbc_pkg::CENT_W-1:0]  centroid_y
);
	import ctbc_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_DIVIDE = 2'b10
	} back_state_t;

	back_state_t       state_q;
	logic [QCNT_W-1:0] steps_q;
	logic              mask_q;
	logic              out_valid_q;

	logic              slot_free;
	logic              load;
	logic              step;
	logic              emit_direct;
	logic              emit_div;
	logic [Q_W-1:0]    quot_x;
	logic [Q_W-1:0]    quot_y;

	assign slot_free = !out_valid_q || out_ready;
	assign step      = (state_q == ST_DIVIDE) && (steps_q != '0);
	assign out_valid = out_valid_q;

	// Sequencing: pop a record, optionally divide, then load the output.
	always_comb begin
		pop         = 1'b0;
		load        = 1'b0;
		emit_direct = 1'b0;
		emit_div    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					if (pop_rec.frame_done && (pop_rec.count != '0)) begin
						pop  = 1'b1;
						load = 1'b1;
					end else if (slot_free) begin
						pop         = 1'b1;
						emit_direct = 1'b1;
					end
				end
			end
			ST_DIVIDE: begin
				if ((steps_q == '0) && slot_free) begin
					emit_div = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Both coordinates share one divisor and step together.
	ctbc_div u_div_x (
		.clk     (clk),
		.load    (load),
		.step    (step),
		.sum     (pop_rec.sum_x),
		.divisor (pop_rec.count),
		.quot    (quot_x)
	);

	ctbc_div u_div_y (
		.clk     (clk),
		.load    (load),
		.step    (step),
		.sum     (pop_rec.sum_y),
		.divisor (pop_rec.count),
		.quot    (quot_y)
	);

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				state_q <= ST_DIVIDE;
				steps_q <= QCNT_W'(Q_W);
			end else if (step) begin
				steps_q <= steps_q - QCNT_W'(1);
			end else if (emit_div) begin
				state_q <= ST_IDLE;
			end
			if (emit_direct || emit_div) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload and the mask bit held across the division.
	always_ff @(posedge clk) begin
		if (load) begin
			mask_q <= pop_rec.mask;
		end
		if (emit_direct) begin
			mask       <= pop_rec.mask;
			frame_done <= pop_rec.frame_done;
			found      <= 1'b0;
			centroid_x <= '0;
			centroid_y <= '0;
		end else if (emit_div) begin
			mask       <= mask_q;
			frame_done <= 1'b1;
			found      <= 1'b1;
			centroid_x <= sat_cent(quot_x);
			centroid_y <= sat_cent(quot_y);
		end
	end

	`CTBC_ASSERT(a_found_at_end, out_valid && found |-> frame_done, "found outside frame end")
	`CTBC_ASSERT(a_zero_mid_frame, out_valid && !frame_done |-> centroid_x == '0 && centroid_y == '0, "centroid set mid-frame")
	`CTBC_NEVER(a_steps_bound, steps_q > QCNT_W'(Q_W), "divider step count out of range")

endmodule

// ===== sv/color_threshold_blob_centroid_core.sv =====
// ----------------------------------------------------------------------------
// color_threshold_blob_centroid_core
// Red-blob mask and centroid tracker for a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in_valid/in_ready channel, one RGB transaction per
// pixel in raster order; each yields one result transaction on the
// out_valid/out_ready channel carrying the mask bit, and on the last pixel
// of the frame also the found flag and the centroid with four fraction bits.
// Frame size and color margin are written through cfg_write, cfg_index and
// cfg_data while the block is idle.
// Throughput is one pixel per cycle while the queue has room. A frame end
// with marked pixels holds the back end while the shared-divisor serial
// dividers produce one quotient bit per cycle; the two-entry queue absorbs
// the first pixels after it, then input stalls. A result passes through a
// queue entry and the output register, at frame end also the division.
// Reset restores 640x400 with margin 100 and clears the counters and sums.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready drops; no transaction is lost.
// ----------------------------------------------------------------------------
module color_threshold_blob_centroid_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ctbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctbc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ctbc_pkg::COLOR_W-1:0]     red,
	input  logic [ctbc_pkg::COLOR_W-1:0]     green,
	input  logic [ctbc_pkg::COLOR_W-1:0]     blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             mask,
	output logic                             frame_done,
	output logic                             found,
	output logic [ctbc_pkg::CENT_W-1:0]      centroid_x,
	output logic [ctbc_pkg::CENT_W-1:0]      centroid_y
);
	import ctbc_pkg::*;

	logic      push;
	logic      pop;
	logic      queue_full;
	logic      queue_empty;
	ctbc_rec_t push_rec;
	ctbc_rec_t pop_rec;

	// Classification, counters and accumulation.
	ctbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.queue_full (queue_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	// Decoupling queue.
	ctbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (queue_full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (queue_empty)
	);

	// Centroid division and output register.
	ctbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (queue_empty),
		.pop_rec    (pop_rec),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mask       (mask),
		.frame_done (frame_done),
		.found      (found),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y)
	);

endmodule

// ===== tb/tb_color_threshold_blob_centroid_core.sv =====
// ----------------------------------------------------------------------------
// tb_color_threshold_blob_centroid_core
// Self-checking bench for the red-blob mask and centroid tracker.
// ----------------------------------------------------------------------------
// A scoreboard class tracks the raster position, the marked-pixel sums and
// the register settings, and predicts the mask, frame end flag and centroid
// of every pixel transaction the block accepts. A short directed sequence
// covers the color threshold edges, out-of-range and mid-frame size changes
// and the spare register index. Random phases follow, each with new
// settings and pixel streams that paint a rectangular blob with noise
// around it. Both handshakes idle at random, and once the result side holds
// off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_color_threshold_blob_centroid_core;
	import ctbc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CFG_MAX_VAL   = (1 << CFG_W) - 1;
	localparam int RANDOM_PIXELS = 550;
	localparam int HOLD_CYCLES   = 150;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic              mask;
		logic              frame_done;
		logic              found;
		logic [CENT_W-1:0] centroid_x;
		logic [CENT_W-1:0] centroid_y;
	} pixel_result_t;

	// Tracks raster position and blob sums, and holds the results still owed.
	class centroid_scoreboard;
		logic [CFG_W-1:0]    frame_width;
		logic [CFG_W-1:0]    frame_height;
		logic [MARGIN_W-1:0] color_margin;
		logic [COL_W-1:0]    column;
		logic [ROW_W-1:0]    row;
		logic [SUM_W-1:0]    sum_columns;
		logic [SUM_W-1:0]    sum_rows;
		logic [CNT_W-1:0]    marked_count;
		pixel_result_t       awaited_q[$];
		int                  mismatches;
		int                  pixels;
		int                  frames;
		int                  found_frames;

		function new();
			frame_width  = WIDTH_RST;
			frame_height = HEIGHT_RST;
			color_margin = MARGIN_RST;
			column       = '0;
			row          = '0;
			sum_columns  = '0;
			sum_rows     = '0;
			marked_count = '0;
			mismatches   = 0;
			pixels       = 0;
			frames       = 0;
			found_frames = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: begin
					frame_width = data;
				end
				REG_FRAME_HEIGHT: begin
					frame_height = data;
				end
				REG_COLOR_MARGIN: begin
					color_margin = data[MARGIN_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// A size of zero behaves as one; anything past the maximum is clipped.
		function int clip_size(logic [CFG_W-1:0] v, int maxv);
			if (v == '0) return 1;
			if (int'(v) > maxv) return maxv;
			return int'(v);
		endfunction

		function int eff_width();
			return clip_size(frame_width, MAX_WIDTH);
		endfunction

		function int eff_height();
			return clip_size(frame_height, MAX_HEIGHT);
		endfunction

		// Mean coordinate with four fraction bits, truncated and saturated.
		function logic [CENT_W-1:0] mean_fix4(logic [SUM_W-1:0] s, logic [CNT_W-1:0] n);
			longint q;
			q = (longint'(s) << FRAC_W) / longint'(n);
			if (q > CENT_MAX) q = CENT_MAX;
			return CENT_W'(q);
		endfunction

		// Classify one accepted pixel and advance the raster position.
		function void note_pixel(pixel_t px);
			int            w;
			int            h;
			bit            marked;
			bit            row_end;
			bit            frame_end;
			pixel_result_t res;
			w = eff_width();
			h = eff_height();
			marked = (int'(px.red) > int'(px.blue) + int'(color_margin)) &&
				(int'(px.red) > int'(px.green) + int'(color_margin));
			row_end   = int'(column) >= w - 1;
			frame_end = row_end && int'(row) >= h - 1;
			if (marked) begin
				sum_columns  = sum_columns + SUM_W'(column);
				sum_rows     = sum_rows + SUM_W'(row);
				marked_count = marked_count + 1'b1;
			end
			res = '0;
			res.mask = marked;
			res.frame_done = frame_end;
			if (frame_end) begin
				frames++;
				if (marked_count != '0) begin
					found_frames++;
					res.found = 1'b1;
					res.centroid_x = mean_fix4(sum_columns, marked_count);
					res.centroid_y = mean_fix4(sum_rows, marked_count);
				end
				sum_columns  = '0;
				sum_rows     = '0;
				marked_count = '0;
				column       = '0;
				row          = '0;
			end else if (row_end) begin
				column = '0;
				row    = row + 1'b1;
			end else begin
				column = column + 1'b1;
			end
			awaited_q.push_back(res);
			pixels++;
		endfunction

		function void compare_field(string name, logic [CENT_W-1:0] want,
				logic [CENT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Match one result transaction against the oldest pixel still owed.
		function void check_result(pixel_result_t got);
			pixel_result_t want;
			if (awaited_q.size() == 0) begin
				$error("Result transaction with no pixel awaiting it");
				mismatches++;
				return;
			end
			want = awaited_q.pop_front();
			compare_field("mask", CENT_W'(want.mask), CENT_W'(got.mask));
			compare_field("frame_done", CENT_W'(want.frame_done), CENT_W'(got.frame_done));
			compare_field("found", CENT_W'(want.found), CENT_W'(got.found));
			compare_field("centroid_x", want.centroid_x, got.centroid_x);
			compare_field("centroid_y", want.centroid_y, got.centroid_y);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [COLOR_W-1:0]   red       = '0;
	logic [COLOR_W-1:0]   green     = '0;
	logic [COLOR_W-1:0]   blue      = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 mask;
	logic                 frame_done;
	logic                 found;
	logic [CENT_W-1:0]    centroid_x;
	logic [CENT_W-1:0]    centroid_y;

	centroid_scoreboard sb = new();
	bit take_gaps      = 1'b1;
	bit pressure_armed = 1'b0;
	bit pressure_done  = 1'b0;
	int stuck_cycles   = 0;
	int settings_used  = 0;

	color_threshold_blob_centroid_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mask       (mask),
		.frame_done (frame_done),
		.found      (found),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly back to back, often a short pause, now and then a long one.
	function automatic int pick_gap(bit allow);
		int roll;
		roll = $urandom_range(0, 99);
		if (!allow || roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// Frame dimension: small most of the time, sometimes zero or oversized.
	function automatic int pick_size(int usual_hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, usual_hi);
		if (roll < 80) return $urandom_range(usual_hi + 1, 40);
		if (roll < 87) return 0;
		if (roll < 94) return $urandom_range(MAX_WIDTH + 1, CFG_MAX_VAL);
		return MAX_WIDTH;
	endfunction

	function automatic pixel_t rgb(int r, int g, int b);
		pixel_t px;
		px.red   = COLOR_W'(r);
		px.green = COLOR_W'(g);
		px.blue  = COLOR_W'(b);
		return px;
	endfunction

	// Random pixel; either clearly red, right at the threshold, or anything.
	function automatic pixel_t pick_pixel(bit want_mark, int margin);
		pixel_t px;
		int     bar;
		px = rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		if (margin < 255 && (want_mark || $urandom_range(0, 3) == 0)) begin
			px.green = COLOR_W'($urandom_range(0, 254 - margin));
			px.blue  = COLOR_W'($urandom_range(0, 254 - margin));
			bar = ((px.green > px.blue) ? int'(px.green) : int'(px.blue)) + margin;
			if (want_mark) begin
				px.red = COLOR_W'($urandom_range(bar + 1, 255));
			end else begin
				px.red = COLOR_W'(bar + $urandom_range(0, 1));
			end
		end
		return px;
	endfunction

	// Offer one pixel transaction and hold it until the block takes it.
	task automatic send_pixel(input pixel_t px, input bit allow_gaps);
		int gap;
		gap = pick_gap(allow_gaps);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		red      <= px.red;
		green    <= px.green;
		blue     <= px.blue;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	// Stop offering pixels and let every owed result come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.awaited_q.size() != 0) @(negedge clk);
	endtask

	// Result side: random back-pressure plus one long hold-off when armed.
	initial begin : result_taker
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pressure_armed && !pressure_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				pressure_done = 1'b1;
			end else begin
				stall = pick_gap(take_gaps);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
		end
	end

	// Check every result transaction and watch for a hung handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result({mask, frame_done, found, centroid_x, centroid_y});
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int     random_pixels;
		int     w;
		int     h;
		int     n;
		int     margin;
		int     c0;
		int     c1;
		int     r0;
		int     r1;
		int     roll;
		bit     has_blob;
		bit     in_blob;
		bit     want_mark;
		bit     send_gaps;
		bit     first_phase;
		pixel_t px;

		random_pixels = 0;
		first_phase   = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Threshold edges at the reset margin, plus all-ones and all-zeros channels.
		settings_used++;
		send_pixel(rgb(255, 0, 0), 1'b1);
		send_pixel(rgb(0, 0, 0), 1'b1);
		send_pixel(rgb(255, 255, 255), 1'b1);
		send_pixel(rgb(200, 50, 100), 1'b1);
		send_pixel(rgb(201, 100, 100), 1'b1);
		send_pixel(rgb(201, 101, 100), 1'b1);

		// Zero-sized frame mid-row: every pixel ends a frame, margin zero.
		wait_drained();
		set_reg(REG_FRAME_WIDTH, '0);
		set_reg(REG_FRAME_HEIGHT, '0);
		set_reg(REG_COLOR_MARGIN, '0);
		cfg_write <= 1'b0;
		settings_used++;
		send_pixel(rgb(1, 0, 0), 1'b1);
		send_pixel(rgb(0, 0, 0), 1'b1);
		send_pixel(rgb(5, 5, 4), 1'b1);

		// Oversized frame and the widest margin; the spare index must do nothing.
		wait_drained();
		set_reg(REG_FRAME_WIDTH, CFG_W'(CFG_MAX_VAL));
		set_reg(REG_FRAME_HEIGHT, CFG_W'(CFG_MAX_VAL));
		set_reg(REG_COLOR_MARGIN, CFG_W'(255));
		set_reg(REG_SPARE, CFG_W'(CFG_MAX_VAL));
		cfg_write <= 1'b0;
		settings_used++;
		repeat (4) send_pixel(rgb(255, 0, 0), 1'b1);

		// Shrink the width below the current column: the row ends at once.
		wait_drained();
		set_reg(REG_FRAME_WIDTH, CFG_W'(3));
		set_reg(REG_FRAME_HEIGHT, CFG_W'(2));
		set_reg(REG_COLOR_MARGIN, '0);
		cfg_write <= 1'b0;
		settings_used++;
		send_pixel(rgb(9, 0, 0), 1'b1);
		repeat (3) send_pixel(rgb(200, 10, 10), 1'b1);

		// Single column, tall frame, then shrink the height below the current row.
		wait_drained();
		set_reg(REG_FRAME_WIDTH, CFG_W'(1));
		set_reg(REG_FRAME_HEIGHT, CFG_W'(CFG_MAX_VAL));
		cfg_write <= 1'b0;
		settings_used++;
		repeat (3) send_pixel(rgb(128, 64, 64), 1'b1);
		wait_drained();
		set_reg(REG_FRAME_HEIGHT, CFG_W'(2));
		cfg_write <= 1'b0;
		settings_used++;
		send_pixel(rgb(0, 255, 0), 1'b1);

		// Random phases: new settings, then frames that paint a blob plus noise.
		while (random_pixels < RANDOM_PIXELS) begin
			wait_drained();
			if (first_phase) begin
				set_reg(REG_FRAME_WIDTH, CFG_W'(8));
				set_reg(REG_FRAME_HEIGHT, CFG_W'(4));
				set_reg(REG_COLOR_MARGIN, CFG_W'(60));
			end else begin
				if ($urandom_range(0, 9) < 8) begin
					set_reg(REG_FRAME_WIDTH, CFG_W'(pick_size(8)));
				end
				if ($urandom_range(0, 9) < 8) begin
					set_reg(REG_FRAME_HEIGHT, CFG_W'(pick_size(6)));
				end
				if ($urandom_range(0, 9) < 8) begin
					roll = $urandom_range(0, 99);
					if (roll < 10) margin = 0;
					else if (roll < 18) margin = 255;
					else if (roll < 30) margin = $urandom_range(0, 255);
					else margin = $urandom_range(20, 120);
					// Upper data bits are don't-care for the margin register.
					set_reg(REG_COLOR_MARGIN,
						{3'($urandom_range(0, 7)), MARGIN_W'(margin)});
				end
				if ($urandom_range(0, 9) == 0) begin
					set_reg(REG_SPARE, CFG_W'($urandom_range(0, CFG_MAX_VAL)));
				end
			end
			cfg_write <= 1'b0;
			settings_used++;

			w = sb.eff_width();
			h = sb.eff_height();
			if (w * h <= 64) begin
				n = w * h * $urandom_range(1, 3) + $urandom_range(0, 3);
			end else begin
				n = $urandom_range(8, 40);
			end
			c0 = $urandom_range(0, w - 1);
			c1 = $urandom_range(c0, w - 1);
			r0 = $urandom_range(0, h - 1);
			r1 = $urandom_range(r0, h - 1);
			has_blob  = $urandom_range(0, 4) != 0;
			send_gaps = $urandom_range(0, 3) != 0;
			take_gaps = $urandom_range(0, 3) != 0;

			// The first phase streams without pauses while the result side holds off.
			if (first_phase) begin
				n = 120;
				send_gaps = 1'b0;
				pressure_armed = 1'b1;
				first_phase = 1'b0;
			end

			for (int k = 0; k < n; k++) begin
				in_blob = int'(sb.column) >= c0 && int'(sb.column) <= c1 &&
					int'(sb.row) >= r0 && int'(sb.row) <= r1;
				want_mark = has_blob && in_blob && $urandom_range(0, 9) != 0;
				if ($urandom_range(0, 19) == 0) want_mark = 1'b1;
				px = pick_pixel(want_mark, int'(sb.color_margin));
				send_pixel(px, send_gaps);
				random_pixels++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d pixel transactions over %0d register settings.",
			sb.pixels, settings_used);
		$display("%0d frames ended, %0d of them with a red blob found.",
			sb.frames, sb.found_frames);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ctbc_pkg.sv
sv/ctbc_front.sv
sv/ctbc_queue.sv
sv/ctbc_div.sv
sv/ctbc_back.sv
sv/color_threshold_blob_centroid_core.sv
tb/tb_color_threshold_blob_centroid_core.sv
